// ===== design/dltrh_pkg.sv =====
// Package for the stored DLT record header parser.
// Holds the phase and field tag codes, the signature constant and the result type.
// No dependencies.
package dltrh_pkg;

  localparam int PhaseW = 4;
  localparam int TagW   = 5;
  localparam int ValueW = 32;

  localparam logic [PhaseW-1:0] PH_HUNT    = 4'd0;
  localparam logic [PhaseW-1:0] PH_SEC     = 4'd1;
  localparam logic [PhaseW-1:0] PH_USEC    = 4'd2;
  localparam logic [PhaseW-1:0] PH_SECU    = 4'd3;
  localparam logic [PhaseW-1:0] PH_HTYP    = 4'd4;
  localparam logic [PhaseW-1:0] PH_MCNT    = 4'd5;
  localparam logic [PhaseW-1:0] PH_LEN     = 4'd6;
  localparam logic [PhaseW-1:0] PH_XECU    = 4'd7;
  localparam logic [PhaseW-1:0] PH_SEID    = 4'd8;
  localparam logic [PhaseW-1:0] PH_TMSP    = 4'd9;
  localparam logic [PhaseW-1:0] PH_MSIN    = 4'd10;
  localparam logic [PhaseW-1:0] PH_NOAR    = 4'd11;
  localparam logic [PhaseW-1:0] PH_APID    = 4'd12;
  localparam logic [PhaseW-1:0] PH_CTID    = 4'd13;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd14;

  localparam logic [TagW-1:0] TAG_SKIP    = 5'd0;
  localparam logic [TagW-1:0] TAG_SEC     = 5'd1;
  localparam logic [TagW-1:0] TAG_USEC    = 5'd2;
  localparam logic [TagW-1:0] TAG_SECU    = 5'd3;
  localparam logic [TagW-1:0] TAG_HTYP    = 5'd4;
  localparam logic [TagW-1:0] TAG_MCNT    = 5'd5;
  localparam logic [TagW-1:0] TAG_LEN     = 5'd6;
  localparam logic [TagW-1:0] TAG_XECU    = 5'd7;
  localparam logic [TagW-1:0] TAG_SEID    = 5'd8;
  localparam logic [TagW-1:0] TAG_TMSP    = 5'd9;
  localparam logic [TagW-1:0] TAG_VERB    = 5'd10;
  localparam logic [TagW-1:0] TAG_TYPE    = 5'd11;
  localparam logic [TagW-1:0] TAG_SUBTYPE = 5'd12;
  localparam logic [TagW-1:0] TAG_NOAR    = 5'd13;
  localparam logic [TagW-1:0] TAG_APID    = 5'd14;
  localparam logic [TagW-1:0] TAG_CTID    = 5'd15;
  localparam logic [TagW-1:0] TAG_PAYLOAD = 5'd16;
  localparam logic [TagW-1:0] TAG_LENERR  = 5'd17;

  localparam logic [31:0] SIGNATURE = 32'h444C_5401;

  localparam logic [7:0] HT_UEH  = 8'h01;
  localparam logic [7:0] HT_WEID = 8'h04;
  localparam logic [7:0] HT_WSID = 8'h08;
  localparam logic [7:0] HT_WTMS = 8'h10;

  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [ValueW-1:0] value;
    logic              last;
  } result_t;

  // Bytes in the field of each phase, minus one.
  function automatic logic [1:0] field_last_pos(input logic [PhaseW-1:0] ph);
    logic [1:0] pos;
    unique case (ph)
      PH_SEC, PH_USEC, PH_SECU, PH_XECU, PH_SEID, PH_TMSP, PH_APID, PH_CTID: pos = 2'd3;
      PH_LEN:  pos = 2'd1;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage

// ===== design/dltrh_parser.sv =====
// Parse state and per-byte decode logic of the stored DLT record header parser.
// Depends on dltrh_pkg.
module dltrh_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output dltrh_pkg::result_t  result
);

  logic [dltrh_pkg::PhaseW-1:0] phase, phase_next;
  logic [23:0] hunt_window, hunt_window_next;
  logic [1:0]  hunt_fill, hunt_fill_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] field_assembly, field_assembly_next;
  logic [7:0]  header_flags, header_flags_next;
  logic [15:0] message_length, message_length_next;
  logic [15:0] payload_remaining, payload_remaining_next;

  function automatic logic [dltrh_pkg::PhaseW-1:0] next_phase(
    input logic [dltrh_pkg::PhaseW-1:0] p, input logic [7:0] flags);
    logic [dltrh_pkg::PhaseW-1:0] n;
    n = p + 4'd1;
    if (n == dltrh_pkg::PH_XECU && (flags & dltrh_pkg::HT_WEID) == 8'd0) n = dltrh_pkg::PH_SEID;
    if (n == dltrh_pkg::PH_SEID && (flags & dltrh_pkg::HT_WSID) == 8'd0) n = dltrh_pkg::PH_TMSP;
    if (n == dltrh_pkg::PH_TMSP && (flags & dltrh_pkg::HT_WTMS) == 8'd0) n = dltrh_pkg::PH_MSIN;
    if (n == dltrh_pkg::PH_MSIN && (flags & dltrh_pkg::HT_UEH) == 8'd0) n = dltrh_pkg::PH_PAYLOAD;
    if (n > dltrh_pkg::PH_PAYLOAD) n = dltrh_pkg::PH_PAYLOAD;
    return n;
  endfunction

  always_comb begin
    logic [31:0] cand;
    logic [31:0] fa;
    logic [4:0]  hdr;
    logic [dltrh_pkg::PhaseW-1:0] nxt;
    logic        restart;

    phase_next             = phase;
    hunt_window_next       = hunt_window;
    hunt_fill_next         = hunt_fill;
    byte_in_field_next     = byte_in_field;
    field_assembly_next    = field_assembly;
    header_flags_next      = header_flags;
    message_length_next    = message_length;
    payload_remaining_next = payload_remaining;
    result                 = '0;
    cand    = {hunt_window, byte_in};
    fa      = '0;
    hdr     = 5'd4;
    nxt     = dltrh_pkg::PH_HUNT;
    restart = 1'b0;

    if (phase == dltrh_pkg::PH_HUNT || phase > dltrh_pkg::PH_PAYLOAD) begin
      phase_next = dltrh_pkg::PH_HUNT;
      if (hunt_fill != 2'd3) begin
        hunt_window_next = cand[23:0];
        hunt_fill_next   = hunt_fill + 2'd1;
      end else if (cand == dltrh_pkg::SIGNATURE) begin
        phase_next          = dltrh_pkg::PH_SEC;
        byte_in_field_next  = '0;
        field_assembly_next = '0;
        hunt_window_next    = '0;
        hunt_fill_next      = '0;
      end else begin
        result.valid     = 1'b1;
        result.tag       = dltrh_pkg::TAG_SKIP;
        result.value     = {24'd0, hunt_window[23:16]};
        hunt_window_next = cand[23:0];
      end
    end else if (phase == dltrh_pkg::PH_PAYLOAD) begin
      result.valid = 1'b1;
      result.tag   = dltrh_pkg::TAG_PAYLOAD;
      result.value = {24'd0, byte_in};
      result.last  = (payload_remaining <= 16'd1);
      if (payload_remaining <= 16'd1) begin
        payload_remaining_next = '0;
        restart                = 1'b1;
      end else begin
        payload_remaining_next = payload_remaining - 16'd1;
      end
    end else begin
      // Storage header times are little-endian; everything else shifts in MSB first.
      if (phase == dltrh_pkg::PH_SEC || phase == dltrh_pkg::PH_USEC) begin
        fa = {byte_in, field_assembly[31:8]};
      end else begin
        fa = {field_assembly[23:0], byte_in};
      end
      field_assembly_next = fa;

      if (byte_in_field != dltrh_pkg::field_last_pos(phase)) begin
        byte_in_field_next = byte_in_field + 2'd1;
        if (phase == dltrh_pkg::PH_APID && byte_in_field == 2'd0) begin
          result.valid = 1'b1;
          result.tag   = dltrh_pkg::TAG_SUBTYPE;
          result.value = {28'd0, message_length[7:4]};
        end else if (phase == dltrh_pkg::PH_APID && byte_in_field == 2'd1) begin
          result.valid = 1'b1;
          result.tag   = dltrh_pkg::TAG_NOAR;
          result.value = {24'd0, message_length[15:8]};
        end
      end else begin
        result.valid = 1'b1;
        result.value = fa;
        unique case (phase)
          dltrh_pkg::PH_SEC:  result.tag = dltrh_pkg::TAG_SEC;
          dltrh_pkg::PH_USEC: result.tag = dltrh_pkg::TAG_USEC;
          dltrh_pkg::PH_SECU: result.tag = dltrh_pkg::TAG_SECU;
          dltrh_pkg::PH_HTYP: begin
            result.tag        = dltrh_pkg::TAG_HTYP;
            result.value      = {24'd0, byte_in};
            header_flags_next = byte_in;
          end
          dltrh_pkg::PH_MCNT: begin
            result.tag   = dltrh_pkg::TAG_MCNT;
            result.value = {24'd0, byte_in};
          end
          dltrh_pkg::PH_LEN: begin
            if ((header_flags & dltrh_pkg::HT_WEID) != 8'd0) hdr = hdr + 5'd4;
            if ((header_flags & dltrh_pkg::HT_WSID) != 8'd0) hdr = hdr + 5'd4;
            if ((header_flags & dltrh_pkg::HT_WTMS) != 8'd0) hdr = hdr + 5'd4;
            if ((header_flags & dltrh_pkg::HT_UEH) != 8'd0)  hdr = hdr + 5'd10;
            message_length_next = fa[15:0];
            result.value        = {16'd0, fa[15:0]};
            if (fa[15:0] < {11'd0, hdr}) begin
              result.tag             = dltrh_pkg::TAG_LENERR;
              payload_remaining_next = '0;
            end else begin
              result.tag             = dltrh_pkg::TAG_LEN;
              payload_remaining_next = fa[15:0] - {11'd0, hdr};
            end
          end
          dltrh_pkg::PH_XECU: result.tag = dltrh_pkg::TAG_XECU;
          dltrh_pkg::PH_SEID: result.tag = dltrh_pkg::TAG_SEID;
          dltrh_pkg::PH_TMSP: result.tag = dltrh_pkg::TAG_TMSP;
          dltrh_pkg::PH_MSIN: begin
            result.tag          = dltrh_pkg::TAG_VERB;
            result.value        = {31'd0, byte_in[0]};
            message_length_next = {8'd0, byte_in};
          end
          dltrh_pkg::PH_NOAR: begin
            result.tag          = dltrh_pkg::TAG_TYPE;
            result.value        = {29'd0, message_length[3:1]};
            message_length_next = {byte_in, message_length[7:0]};
          end
          dltrh_pkg::PH_APID: result.tag = dltrh_pkg::TAG_APID;
          default:            result.tag = dltrh_pkg::TAG_CTID;
        endcase

        nxt = next_phase(phase, header_flags_next);
        if (nxt == dltrh_pkg::PH_PAYLOAD && payload_remaining_next == 16'd0) begin
          result.last = 1'b1;
          restart     = 1'b1;
        end else begin
          phase_next          = nxt;
          byte_in_field_next  = '0;
          field_assembly_next = '0;
        end
      end
    end

    if (restart) begin
      phase_next          = dltrh_pkg::PH_HUNT;
      hunt_window_next    = '0;
      hunt_fill_next      = '0;
      byte_in_field_next  = '0;
      field_assembly_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= dltrh_pkg::PH_HUNT;
      hunt_window       <= '0;
      hunt_fill         <= '0;
      byte_in_field     <= '0;
      field_assembly    <= '0;
      header_flags      <= '0;
      message_length    <= '0;
      payload_remaining <= '0;
    end else if (step) begin
      phase             <= phase_next;
      hunt_window       <= hunt_window_next;
      hunt_fill         <= hunt_fill_next;
      byte_in_field     <= byte_in_field_next;
      field_assembly    <= field_assembly_next;
      header_flags      <= header_flags_next;
      message_length    <= message_length_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

// ===== design/dlt_record_header_parser_top.sv =====
// Stored DLT record header parser: an accepted byte goes through the input register,
// then its result through the result register on the master side.
// Throughput is one byte per cycle unless the master side stalls; a byte that yields
// no field takes its cycle too. The parse state sits between the two registers and
// is updated once per byte. Reset (rst, synchronous) empties both registers and
// restarts the signature hunt. Depends on dltrh_pkg and dltrh_parser.
module dlt_record_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] field_value
  output logic [4:0]  m_tuser,   // [4:0] field_tag
  output logic        m_tlast    // record_end
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic [4:0]         out_tag;
  logic [31:0]        out_value;
  logic               out_end;
  logic               advance;
  dltrh_pkg::result_t result;

  // The held byte is decoded once the result register can take its outcome.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  dltrh_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (in_valid && !advance) || (s_tvalid && s_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_tag   <= result.tag;
      out_value <= result.value;
      out_end   <= result.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_tag;
  assign m_tlast  = out_end;

endmodule

// ===== design/dltrh_checker.sv =====
// Port-level checks for the stored DLT record header parser, bound to the top level.
// Depends on dltrh_pkg and dlt_record_header_parser_top.
module dltrh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled request keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A skipped byte never closes a record and carries just that byte.
  a_skip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dltrh_pkg::TAG_SKIP |-> !m_tlast && m_tdata[31:8] == 24'd0)
    else $error("bad skipped result");

  // Only defined tags appear.
  a_tag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= dltrh_pkg::TAG_LENERR)
    else $error("undefined field tag");

  // Payload bytes are eight bits wide.
  a_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dltrh_pkg::TAG_PAYLOAD |-> m_tdata[31:8] == 24'd0)
    else $error("payload value too wide");

  // Nothing is offered in the first cycle after reset is released.
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind dlt_record_header_parser_top dltrh_checker u_dltrh_checker (.*);

// ===== sim/tb_dlt_record_header_parser_top.sv =====
// Self-checking testbench for dlt_record_header_parser_top: a short table of directed bytes,
// then random stored records and noise, each result checked against a local predictor.
// Depends on dltrh_pkg and the parser RTL.
module tb_dlt_record_header_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dltrh_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseBytes    = 540;
  localparam int MaxReported   = 10;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [ValueW-1:0] value;
    logic              last;
  } field_rec_t;

  // One directed byte; res is only used when typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic       has_res;
    field_rec_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] field_value
  logic [4:0]  m_tuser;   // [4:0] field_tag
  logic        m_tlast;   // record_end

  dlt_record_header_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [PhaseW-1:0] phase_q;
  logic [23:0]       window_q;
  logic [1:0]        fill_q;
  logic [1:0]        pos_q;
  logic [31:0]       asm_q;
  logic [7:0]        htyp_q;
  logic [15:0]       mlen_q;
  logic [15:0]       remain_q;

  field_rec_t  pending_fields[$];
  logic [7:0]  burst_q[$];
  int          send_idle_pct = 8;
  int          recv_idle_pct = 45;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          records_built = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  logic [17:0] tags_seen = '0;

  // Hunt start, false start "?DLT", then a record with version bits set, the extended
  // header, a length shorter than its headers and hence no payload.
  dir_row_t dir_rows [31] = '{
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h44, 1'b1, 1'b0, '0},
    '{8'h4C, 1'b1, 1'b0, '0},
    '{8'h54, 1'b1, 1'b1, '{TAG_SKIP, 32'h0000_00FF, 1'b0}},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'h02, 1'b1, 1'b0, '0},
    '{8'h03, 1'b1, 1'b0, '0},
    '{8'h04, 1'b1, 1'b1, '{TAG_SEC, 32'h0403_0201, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{TAG_USEC, 32'hFFFF_FFFF, 1'b0}},
    '{8'h45, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'hE1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{TAG_MCNT, 32'd0, 1'b0}},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h03, 1'b1, 1'b1, '{TAG_LENERR, 32'd3, 1'b0}},
    '{8'h4B, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h54, 1'b0, 1'b0, '0},
    '{8'h58, 1'b0, 1'b0, '0},
    '{8'h30, 1'b0, 1'b0, '0}
  };

  function automatic int field_bytes(input logic [PhaseW-1:0] ph);
    case (ph)
      PH_SEC, PH_USEC, PH_SECU, PH_XECU, PH_SEID, PH_TMSP, PH_APID, PH_CTID: return 4;
      PH_LEN:  return 2;
      default: return 1;
    endcase
  endfunction

  // Optional headers are skipped when their htyp bit is clear; without the extended
  // header the payload follows the last standard-header field.
  function automatic logic [PhaseW-1:0] following_phase(input logic [PhaseW-1:0] ph,
                                                        input logic [7:0] flags);
    logic [PhaseW-1:0] q;
    q = ph + 1'b1;
    if (q == PH_XECU && (flags & HT_WEID) == 8'd0) q = q + 1'b1;
    if (q == PH_SEID && (flags & HT_WSID) == 8'd0) q = q + 1'b1;
    if (q == PH_TMSP && (flags & HT_WTMS) == 8'd0) q = q + 1'b1;
    if (q == PH_MSIN && (flags & HT_UEH) == 8'd0) q = PH_PAYLOAD;
    if (q > PH_PAYLOAD) q = PH_PAYLOAD;
    return q;
  endfunction

  task automatic restart_hunt();
    phase_q  = PH_HUNT;
    window_q = '0;
    fill_q   = '0;
    pos_q    = '0;
    asm_q    = '0;
  endtask

  task automatic predict_field(input logic [7:0] b, output logic got, output field_rec_t rec);
    logic [31:0]       cand;
    logic [PhaseW-1:0] nxt;
    int                hdr;
    got = 1'b0;
    rec = '0;
    if (phase_q == PH_HUNT || phase_q > PH_PAYLOAD) begin
      if (fill_q < 2'd3) begin
        window_q = {window_q[15:0], b};
        fill_q   = fill_q + 2'd1;
        phase_q  = PH_HUNT;
      end else begin
        cand = {window_q, b};
        if (cand == SIGNATURE) begin
          phase_q  = PH_SEC;
          pos_q    = '0;
          asm_q    = '0;
          window_q = '0;
          fill_q   = '0;
        end else begin
          got       = 1'b1;
          rec.tag   = TAG_SKIP;
          rec.value = {24'd0, window_q[23:16]};
          window_q  = cand[23:0];
        end
      end
    end else if (phase_q == PH_PAYLOAD) begin
      got       = 1'b1;
      rec.tag   = TAG_PAYLOAD;
      rec.value = {24'd0, b};
      rec.last  = (remain_q <= 16'd1);
      if (remain_q <= 16'd1) begin
        remain_q = '0;
        restart_hunt();
      end else begin
        remain_q = remain_q - 16'd1;
      end
    end else begin
      // Storage-header times are little-endian, everything else big-endian.
      if (phase_q == PH_SEC || phase_q == PH_USEC) asm_q = {b, asm_q[31:8]};
      else asm_q = {asm_q[23:0], b};
      if (int'(pos_q) + 1 < field_bytes(phase_q)) begin
        // The msin split finishes on the first two bytes of the application id.
        if (phase_q == PH_APID && pos_q == 2'd0) begin
          got       = 1'b1;
          rec.tag   = TAG_SUBTYPE;
          rec.value = {28'd0, mlen_q[7:4]};
        end else if (phase_q == PH_APID && pos_q == 2'd1) begin
          got       = 1'b1;
          rec.tag   = TAG_NOAR;
          rec.value = {24'd0, mlen_q[15:8]};
        end
        pos_q = pos_q + 2'd1;
      end else begin
        got = 1'b1;
        rec.value = asm_q;
        case (phase_q)
          PH_SEC:  rec.tag = TAG_SEC;
          PH_USEC: rec.tag = TAG_USEC;
          PH_SECU: rec.tag = TAG_SECU;
          PH_HTYP: begin
            rec.tag   = TAG_HTYP;
            rec.value = {24'd0, b};
            htyp_q    = b;
          end
          PH_MCNT: begin
            rec.tag   = TAG_MCNT;
            rec.value = {24'd0, b};
          end
          PH_LEN: begin
            hdr = 4;
            if ((htyp_q & HT_WEID) != 8'd0) hdr += 4;
            if ((htyp_q & HT_WSID) != 8'd0) hdr += 4;
            if ((htyp_q & HT_WTMS) != 8'd0) hdr += 4;
            if ((htyp_q & HT_UEH) != 8'd0) hdr += 10;
            mlen_q    = asm_q[15:0];
            rec.value = {16'd0, asm_q[15:0]};
            if (int'(asm_q[15:0]) < hdr) begin
              rec.tag  = TAG_LENERR;
              remain_q = '0;
            end else begin
              rec.tag  = TAG_LEN;
              remain_q = asm_q[15:0] - 16'(hdr);
            end
          end
          PH_XECU: rec.tag = TAG_XECU;
          PH_SEID: rec.tag = TAG_SEID;
          PH_TMSP: rec.tag = TAG_TMSP;
          PH_MSIN: begin
            rec.tag   = TAG_VERB;
            rec.value = {31'd0, b[0]};
            mlen_q    = {8'd0, b};
          end
          PH_NOAR: begin
            rec.tag   = TAG_TYPE;
            rec.value = {29'd0, mlen_q[3:1]};
            mlen_q    = {b, mlen_q[7:0]};
          end
          PH_APID: rec.tag = TAG_APID;
          default: rec.tag = TAG_CTID;
        endcase
        nxt = following_phase(phase_q, htyp_q);
        if (nxt == PH_PAYLOAD && remain_q == 16'd0) begin
          rec.last = 1'b1;
          restart_hunt();
        end else begin
          phase_q = nxt;
          pos_q   = '0;
          asm_q   = '0;
        end
      end
    end
  endtask

  // A request is taken at a rising edge with s_tvalid and s_tready both high.
  task automatic send_byte(input dir_row_t row);
    logic       got;
    field_rec_t rec;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.data;
    do @(posedge clk); while (!s_tready);
    predict_field(row.data, got, rec);
    if (row.typed) begin
      got = row.has_res;
      rec = row.res;
    end
    if (got) pending_fields.push_back(rec);
    bytes_sent++;
  endtask

  task automatic send_burst();
    dir_row_t row;
    row = '0;
    while (burst_q.size() != 0) begin
      row.data = burst_q.pop_front();
      send_byte(row);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
  endtask

  task automatic push_random(input int count);
    repeat (count) burst_q.push_back(8'($urandom));
  endtask

  // A well-formed record with random content; the length is mostly right, sometimes short,
  // and now and then long enough to carry a payload of 13 to 300 bytes.
  task automatic build_record();
    logic [7:0]  htyp;
    logic [15:0] len;
    int          hdr;
    int          pay;
    int          pick;
    htyp = 8'($urandom);
    hdr  = 4;
    if ((htyp & HT_WEID) != 8'd0) hdr += 4;
    if ((htyp & HT_WSID) != 8'd0) hdr += 4;
    if ((htyp & HT_WTMS) != 8'd0) hdr += 4;
    if ((htyp & HT_UEH) != 8'd0) hdr += 10;
    pick = $urandom_range(99);
    pay  = 0;
    if (pick < 8) begin
      len = 16'($urandom_range(hdr - 1, 0));
    end else begin
      pay = (pick < 11) ? $urandom_range(300, 13) : $urandom_range(12, 0);
      len = 16'(hdr + pay);
    end
    burst_q.push_back(SIGNATURE[31:24]);
    burst_q.push_back(SIGNATURE[23:16]);
    burst_q.push_back(SIGNATURE[15:8]);
    burst_q.push_back(SIGNATURE[7:0]);
    push_random(12);
    burst_q.push_back(htyp);
    push_random(1);
    burst_q.push_back(len[15:8]);
    burst_q.push_back(len[7:0]);
    push_random(hdr - 4 + pay);
    records_built++;
  endtask

  // Noise between records: loose bytes, or a signature broken in its last byte.
  task automatic build_noise();
    if ($urandom_range(1) == 0) begin
      push_random($urandom_range(6, 1));
    end else begin
      burst_q.push_back(SIGNATURE[31:24]);
      burst_q.push_back(SIGNATURE[23:16]);
      burst_q.push_back(SIGNATURE[15:8]);
      burst_q.push_back(8'($urandom_range(255, 2)));
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    field_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser < 5'd18) tags_seen[m_tuser] = 1'b1;
      if (pending_fields.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported)
          $display("unexpected result: tag %0d value %h last %b", m_tuser, m_tdata, m_tlast);
      end else begin
        want = pending_fields.pop_front();
        if (m_tuser !== want.tag || m_tdata !== want.value || m_tlast !== want.last) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("mismatch: tag exp %0d got %0d, value exp %h got %h, last exp %b got %b",
                     want.tag, m_tuser, want.value, m_tdata, want.last, m_tlast);
        end
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("tb_dlt_record_header_parser_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    restart_hunt();
    htyp_q   = '0;
    mlen_q   = '0;
    remain_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(99) < 80) build_record();
        else build_noise();
        // Now and then a record is cut short, so the next one lands mid-header.
        if ($urandom_range(99) < 5 && burst_q.size() > 1)
          repeat ($urandom_range(burst_q.size() - 1, 1)) void'(burst_q.pop_back());
        send_burst();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (pending_fields.size() != 0)
      $display("%0d expected results never arrived", pending_fields.size());
    $display("summary: %0d bytes in, %0d random records, %0d fields out",
             bytes_sent, records_built, results_seen);
    $display("summary: %0d of 18 field kinds seen", $countones(tags_seen));
    if (fail_count == 0 && pending_fields.size() == 0) begin
      $display("tb_dlt_record_header_parser_top: done, clean");
    end else begin
      $display("tb_dlt_record_header_parser_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dltrh_pkg.sv
design/dltrh_parser.sv
design/dlt_record_header_parser_top.sv
design/dltrh_checker.sv
sim/tb_dlt_record_header_parser_top.sv
